>>> src/sebp_pkg.sv
// ----------------------------------------------------------------------------
// sebp_pkg
// Shared constants, codes and types of the spectral energy bin packetiser.
// ----------------------------------------------------------------------------
package sebp_pkg;

   // frame geometry and field widths
   localparam int FRAME_SIZE = 256;
   localparam int HALF_BINS  = FRAME_SIZE / 2;
   localparam int IDX_W      = $clog2(HALF_BINS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int BIN_W      = 24;
   localparam int EN_W       = 2 * BIN_W;
   localparam int TOT_W      = 54;
   localparam int PCT_W      = 7;
   localparam int THR_W      = TOT_W + PCT_W;
   localparam int Q_W        = 16;
   localparam int QBITS      = 15;
   localparam int DQ_W       = BIN_W + QBITS;
   localparam int SEQ_W      = 16;
   localparam int DIV_W      = $clog2(QBITS + 1);

   localparam logic [PCT_W-1:0] PCT_RESET  = PCT_W'(95);
   localparam logic [15:0]      SYNC_WORD  = 16'hA55A;
   localparam logic [15:0]      FRAME_WORD = 16'(FRAME_SIZE);
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(HALF_BINS - 1);

   // record kinds
   localparam logic [1:0] REC_HEADER = 2'd0;
   localparam logic [1:0] REC_BIN    = 2'd1;
   localparam logic [1:0] REC_TAIL   = 2'd2;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE, ST_EN_RD, ST_EN_MUL, ST_EN_ACC,
      ST_RK_EK, ST_RK_LD, ST_RK_SCAN, ST_RK_WR,
      ST_SEL_INIT, ST_SEL_CHK, ST_SEL_ORD, ST_SEL_ADD,
      ST_PK_INIT, ST_PK_CHK, ST_PK_ORD, ST_PK_DAT, ST_FIN,
      ST_RD_IDX, ST_RD_LD, ST_RD_DIV, ST_RD_OUT
   } state_type;

   // datapath commands
   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_HDR, OP_BIN_ORD, OP_TAIL,
      OP_EN_RD, OP_EN_MUL, OP_EN_ACC,
      OP_RK_EK, OP_RK_LD, OP_RK_SCAN, OP_RK_WR,
      OP_SEL_INIT, OP_SEL_CHK, OP_SEL_ORD, OP_SEL_ADD,
      OP_PK_INIT, OP_PK_CHK, OP_PK_ORD, OP_PK_DAT, OP_FIN,
      OP_RD_IDX, OP_RD_LD, OP_RD_DIV, OP_RD_OUT
   } op_type;

   // datapath status towards the controller
   typedef struct packed {
      logic load_last;
      logic pkt_ready;
      logic rp_zero;
      logic rp_bin;
      logic k_last;
      logic scan_done;
      logic sel_go;
      logic pk_go;
      logic div_last;
   } status_type;

   // magnitude of a signed bin component
   function automatic logic [BIN_W-1:0] mag_of(input logic signed [BIN_W-1:0] v);
      logic [BIN_W-1:0] r;
      r = v[BIN_W-1] ? BIN_W'(-v) : BIN_W'(v);
      return r;
   endfunction

endpackage

>>> src/sebp_ctrl.sv
// ----------------------------------------------------------------------------
// sebp_ctrl
// Sequencer: runs the per-frame passes and the record reads by commands.
// ----------------------------------------------------------------------------
module sebp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_kind,
   input  sebp_pkg::status_type status,
   output sebp_pkg::op_type    op,
   output logic                busy
);
   import sebp_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!req_kind) begin
                  if (status.load_last) state_in = ST_EN_RD;
               end else if (status.pkt_ready && !status.rp_zero && status.rp_bin) begin
                  state_in = ST_RD_IDX;
               end
            end
         end
         ST_EN_RD:    state_in = ST_EN_MUL;
         ST_EN_MUL:   state_in = ST_EN_ACC;
         ST_EN_ACC:   state_in = status.k_last ? ST_RK_EK : ST_EN_RD;
         ST_RK_EK:    state_in = ST_RK_LD;
         ST_RK_LD:    state_in = ST_RK_SCAN;
         ST_RK_SCAN:  state_in = status.scan_done ? ST_RK_WR : ST_RK_SCAN;
         ST_RK_WR:    state_in = status.k_last ? ST_SEL_INIT : ST_RK_EK;
         ST_SEL_INIT: state_in = ST_SEL_CHK;
         ST_SEL_CHK:  state_in = status.sel_go ? ST_SEL_ORD : ST_PK_INIT;
         ST_SEL_ORD:  state_in = ST_SEL_ADD;
         ST_SEL_ADD:  state_in = ST_SEL_CHK;
         ST_PK_INIT:  state_in = ST_PK_CHK;
         ST_PK_CHK:   state_in = status.pk_go ? ST_PK_ORD : ST_FIN;
         ST_PK_ORD:   state_in = ST_PK_DAT;
         ST_PK_DAT:   state_in = ST_PK_CHK;
         ST_FIN:      state_in = ST_IDLE;
         ST_RD_IDX:   state_in = ST_RD_LD;
         ST_RD_LD:    state_in = ST_RD_DIV;
         ST_RD_DIV:   state_in = status.div_last ? ST_RD_OUT : ST_RD_DIV;
         ST_RD_OUT:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      op   = OP_NONE;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!req_kind) begin
                  op = OP_LOAD;
               end else if (status.pkt_ready) begin
                  if (status.rp_zero)     op = OP_HDR;
                  else if (status.rp_bin) op = OP_BIN_ORD;
                  else                    op = OP_TAIL;
               end
            end
         end
         ST_EN_RD:    op = OP_EN_RD;
         ST_EN_MUL:   op = OP_EN_MUL;
         ST_EN_ACC:   op = OP_EN_ACC;
         ST_RK_EK:    op = OP_RK_EK;
         ST_RK_LD:    op = OP_RK_LD;
         ST_RK_SCAN:  op = OP_RK_SCAN;
         ST_RK_WR:    op = OP_RK_WR;
         ST_SEL_INIT: op = OP_SEL_INIT;
         ST_SEL_CHK:  op = OP_SEL_CHK;
         ST_SEL_ORD:  op = OP_SEL_ORD;
         ST_SEL_ADD:  op = OP_SEL_ADD;
         ST_PK_INIT:  op = OP_PK_INIT;
         ST_PK_CHK:   op = OP_PK_CHK;
         ST_PK_ORD:   op = OP_PK_ORD;
         ST_PK_DAT:   op = OP_PK_DAT;
         ST_FIN:      op = OP_FIN;
         ST_RD_IDX:   op = OP_RD_IDX;
         ST_RD_LD:    op = OP_RD_LD;
         ST_RD_DIV:   op = OP_RD_DIV;
         ST_RD_OUT:   op = OP_RD_OUT;
         default:     op = OP_NONE;
      endcase
   end

endmodule

>>> src/sebp_dpath.sv
// ----------------------------------------------------------------------------
// sebp_dpath
// Bin stores, energy and ranking passes, selection, peak search, Q15 divider
// and the record output register.
// ----------------------------------------------------------------------------
module sebp_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sebp_pkg::op_type                      op,
   input  logic signed [sebp_pkg::BIN_W-1:0]     req_bin_re,
   input  logic signed [sebp_pkg::BIN_W-1:0]     req_bin_im,
   input  logic                                  csr_wr_en,
   input  logic [sebp_pkg::PCT_W-1:0]            csr_wr_data,
   output sebp_pkg::status_type                  status,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_record_kind,
   output logic [sebp_pkg::IDX_W-1:0]            rsp_bin_index,
   output logic signed [sebp_pkg::Q_W-1:0]       rsp_re_q15,
   output logic signed [sebp_pkg::Q_W-1:0]       rsp_im_q15,
   output logic [sebp_pkg::IDX_W-1:0]            rsp_kept_count,
   output logic [sebp_pkg::SEQ_W-1:0]            rsp_sequence_res,
   output logic [sebp_pkg::TOT_W-1:0]            rsp_total_energy,
   output logic [7:0]                            rsp_checksum,
   output logic                                  rsp_last
);
   import sebp_pkg::*;

   // memories
   logic signed [BIN_W-1:0] re_mem [HALF_BINS];
   logic signed [BIN_W-1:0] im_mem [HALF_BINS];
   logic [EN_W-1:0]         en_mem [HALF_BINS];
   logic [IDX_W-1:0]        ord_mem [HALF_BINS];

   logic signed [BIN_W-1:0] re_q, im_q;
   logic [EN_W-1:0]         en_q;
   logic [IDX_W-1:0]        ord_q;
   logic [IDX_W-1:0]        bin_rd_addr, en_rd_addr, ord_rd_addr;

   // control state
   logic [PCT_W-1:0] pct_ff;
   logic [IDX_W-1:0] load_cnt_ff;
   logic             ready_ff;
   logic [CNT_W-1:0] rp_ff;
   logic [SEQ_W-1:0] seq_ctr_ff, pkt_seq_ff;
   logic [IDX_W-1:0] k_ff, n_ff, rank_ff;
   logic [CNT_W-1:0] j_ff;
   logic [DIV_W-1:0] div_cnt_ff;
   logic             rsp_valid_ff;

   // payload state
   logic [TOT_W-1:0] total_ff, acc_ff;
   logic [THR_W-1:0] thr_ff;
   logic [EN_W-1:0]  sq_re_ff, sq_im_ff, ek_ff;
   logic [BIN_W-1:0] peak_ff;
   logic [7:0]       csum_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [BIN_W-1:0] rem_re_ff, rem_im_ff;
   logic [QBITS-1:0] sh_re_ff, sh_im_ff;
   logic             neg_re_ff, neg_im_ff;

   logic [1:0]             rec_kind_ff;
   logic [IDX_W-1:0]       rec_idx_ff, rec_cnt_ff;
   logic signed [Q_W-1:0]  rec_re_ff, rec_im_ff;
   logic [SEQ_W-1:0]       rec_seq_ff;
   logic [TOT_W-1:0]       rec_tot_ff;
   logic [7:0]             rec_csum_ff;
   logic                   rec_last_ff;

   // read address selection
   always_comb begin
      bin_rd_addr = (op == OP_EN_RD) ? k_ff : ord_q;
      case (op)
         OP_RK_EK:   en_rd_addr = k_ff;
         OP_RK_SCAN: en_rd_addr = j_ff[IDX_W-1:0];
         default:    en_rd_addr = ord_q;
      endcase
      case (op)
         OP_SEL_CHK: ord_rd_addr = n_ff;
         OP_PK_CHK:  ord_rd_addr = k_ff;
         default:    ord_rd_addr = IDX_W'(rp_ff - CNT_W'(1));
      endcase
   end

   // bin stores
   always_ff @(posedge clock) begin
      if (op == OP_LOAD) begin
         re_mem[load_cnt_ff] <= req_bin_re;
         im_mem[load_cnt_ff] <= req_bin_im;
      end
      re_q <= re_mem[bin_rd_addr];
      im_q <= im_mem[bin_rd_addr];
   end

   // energy store
   logic [EN_W-1:0] energy_sum;
   assign energy_sum = sq_re_ff + sq_im_ff;

   always_ff @(posedge clock) begin
      if (op == OP_EN_ACC) begin
         en_mem[k_ff] <= energy_sum;
      end
      en_q <= en_mem[en_rd_addr];
   end

   // order store
   always_ff @(posedge clock) begin
      if (op == OP_RK_WR) begin
         ord_mem[rank_ff] <= k_ff;
      end
      ord_q <= ord_mem[ord_rd_addr];
   end

   // ranking compare: earlier in order when larger, or equal with lower index
   logic [IDX_W-1:0] j_prev;
   logic             beats;
   assign j_prev = IDX_W'(j_ff - CNT_W'(1));
   assign beats  = (en_q > ek_ff) || ((en_q == ek_ff) && (j_prev < k_ff));

   // threshold test of the selection pass
   logic [THR_W-1:0] acc100;
   assign acc100 = (THR_W'(acc_ff) << 6) + (THR_W'(acc_ff) << 5) + (THR_W'(acc_ff) << 2);

   // peak candidates
   logic [BIN_W-1:0] mag_re, mag_im, pk_a;
   assign mag_re = mag_of(re_q);
   assign mag_im = mag_of(im_q);
   assign pk_a   = (mag_re > peak_ff) ? mag_re : peak_ff;

   // divider load and step
   logic [DQ_W-1:0]  dq_re, dq_im;
   logic [BIN_W:0]   t_re, t_im;
   logic             ge_re, ge_im;
   assign dq_re = (DQ_W'(mag_re) << QBITS) - DQ_W'(mag_re);
   assign dq_im = (DQ_W'(mag_im) << QBITS) - DQ_W'(mag_im);
   assign t_re  = {rem_re_ff, sh_re_ff[QBITS-1]};
   assign t_im  = {rem_im_ff, sh_im_ff[QBITS-1]};
   assign ge_re = (t_re >= {1'b0, peak_ff});
   assign ge_im = (t_im >= {1'b0, peak_ff});

   // signed Q15 results
   logic signed [Q_W-1:0] q_re, q_im;
   assign q_re = neg_re_ff ? -Q_W'(sh_re_ff) : Q_W'(sh_re_ff);
   assign q_im = neg_im_ff ? -Q_W'(sh_im_ff) : Q_W'(sh_im_ff);

   // header and bin word checksums
   logic [7:0] hdr_xor, bin_xor;
   always_comb begin
      hdr_xor = SYNC_WORD[7:0] ^ SYNC_WORD[15:8] ^ FRAME_WORD[7:0] ^ FRAME_WORD[15:8]
              ^ {1'b0, n_ff} ^ pkt_seq_ff[7:0] ^ pkt_seq_ff[15:8];
      for (int b = 0; b < 7; b++) begin
         hdr_xor = hdr_xor ^ 8'({2'b00, total_ff} >> (8 * b));
      end
      bin_xor = csum_ff ^ {1'b0, idx_ff} ^ q_re[7:0] ^ q_re[15:8] ^ q_im[7:0] ^ q_im[15:8];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff       <= PCT_RESET;
         load_cnt_ff  <= '0;
         ready_ff     <= 1'b0;
         rp_ff        <= '0;
         seq_ctr_ff   <= '0;
         pkt_seq_ff   <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
         rank_ff      <= '0;
         j_ff         <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         peak_ff      <= BIN_W'(1);
         csum_ff      <= '0;
      end else begin
         if (csr_wr_en) pct_ff <= csr_wr_data;
         rsp_valid_ff <= (op == OP_HDR) || (op == OP_TAIL) || (op == OP_RD_OUT);
         case (op)
            OP_LOAD: begin
               ready_ff    <= 1'b0;
               load_cnt_ff <= load_cnt_ff + IDX_W'(1);
               if (load_cnt_ff == IDX_LAST) begin
                  k_ff     <= IDX_W'(1);
                  total_ff <= '0;
               end
            end
            OP_HDR: begin
               csum_ff <= hdr_xor;
               rp_ff   <= CNT_W'(1);
            end
            OP_TAIL: begin
               rp_ff    <= '0;
               ready_ff <= 1'b0;
            end
            OP_EN_ACC: begin
               total_ff <= total_ff + TOT_W'(energy_sum);
               k_ff     <= (k_ff == IDX_LAST) ? IDX_W'(1) : k_ff + IDX_W'(1);
            end
            OP_RK_LD: begin
               j_ff    <= CNT_W'(1);
               rank_ff <= '0;
            end
            OP_RK_SCAN: begin
               j_ff <= j_ff + CNT_W'(1);
               if (j_ff >= CNT_W'(2) && beats) rank_ff <= rank_ff + IDX_W'(1);
            end
            OP_RK_WR:    k_ff <= k_ff + IDX_W'(1);
            OP_SEL_INIT: n_ff <= '0;
            OP_SEL_ADD:  n_ff <= n_ff + IDX_W'(1);
            OP_PK_INIT: begin
               k_ff    <= '0;
               peak_ff <= BIN_W'(1);
            end
            OP_PK_DAT: begin
               k_ff    <= k_ff + IDX_W'(1);
               peak_ff <= (mag_im > pk_a) ? mag_im : pk_a;
            end
            OP_FIN: begin
               pkt_seq_ff <= seq_ctr_ff;
               seq_ctr_ff <= seq_ctr_ff + SEQ_W'(1);
               rp_ff      <= '0;
               csum_ff    <= '0;
               ready_ff   <= 1'b1;
            end
            OP_RD_LD:  div_cnt_ff <= DIV_W'(QBITS);
            OP_RD_DIV: div_cnt_ff <= div_cnt_ff - DIV_W'(1);
            OP_RD_OUT: begin
               csum_ff <= bin_xor;
               rp_ff   <= rp_ff + CNT_W'(1);
            end
            default: ;
         endcase
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      case (op)
         OP_EN_MUL: begin
            sq_re_ff <= EN_W'(re_q * re_q);
            sq_im_ff <= EN_W'(im_q * im_q);
         end
         OP_RK_LD:    ek_ff <= en_q;
         OP_SEL_INIT: begin
            thr_ff <= THR_W'(pct_ff) * THR_W'(total_ff);
            acc_ff <= '0;
         end
         OP_SEL_ADD:  acc_ff <= acc_ff + TOT_W'(en_q);
         OP_RD_IDX:   idx_ff <= ord_q;
         OP_RD_LD: begin
            rem_re_ff <= dq_re[DQ_W-1:QBITS];
            sh_re_ff  <= dq_re[QBITS-1:0];
            rem_im_ff <= dq_im[DQ_W-1:QBITS];
            sh_im_ff  <= dq_im[QBITS-1:0];
            neg_re_ff <= re_q[BIN_W-1];
            neg_im_ff <= im_q[BIN_W-1];
         end
         OP_RD_DIV: begin
            rem_re_ff <= ge_re ? BIN_W'(t_re - {1'b0, peak_ff}) : t_re[BIN_W-1:0];
            rem_im_ff <= ge_im ? BIN_W'(t_im - {1'b0, peak_ff}) : t_im[BIN_W-1:0];
            sh_re_ff  <= {sh_re_ff[QBITS-2:0], ge_re};
            sh_im_ff  <= {sh_im_ff[QBITS-2:0], ge_im};
         end
         default: ;
      endcase
   end

   // result word register
   always_ff @(posedge clock) begin
      if (op == OP_HDR || op == OP_TAIL || op == OP_RD_OUT) begin
         rec_kind_ff <= REC_HEADER;
         rec_idx_ff  <= '0;
         rec_re_ff   <= '0;
         rec_im_ff   <= '0;
         rec_cnt_ff  <= '0;
         rec_seq_ff  <= '0;
         rec_tot_ff  <= '0;
         rec_csum_ff <= '0;
         rec_last_ff <= 1'b0;
         case (op)
            OP_HDR: begin
               rec_cnt_ff <= n_ff;
               rec_seq_ff <= pkt_seq_ff;
               rec_tot_ff <= total_ff;
            end
            OP_RD_OUT: begin
               rec_kind_ff <= REC_BIN;
               rec_idx_ff  <= idx_ff;
               rec_re_ff   <= q_re;
               rec_im_ff   <= q_im;
            end
            default: begin
               rec_kind_ff <= REC_TAIL;
               rec_csum_ff <= csum_ff;
               rec_last_ff <= 1'b1;
            end
         endcase
      end
   end

   // status
   always_comb begin
      status.load_last = (load_cnt_ff == IDX_LAST);
      status.pkt_ready = ready_ff;
      status.rp_zero   = (rp_ff == '0);
      status.rp_bin    = (rp_ff <= {1'b0, n_ff});
      status.k_last    = (k_ff == IDX_LAST);
      status.scan_done = (j_ff == CNT_W'(HALF_BINS));
      status.sel_go    = (n_ff != IDX_LAST) && (acc100 < thr_ff);
      status.pk_go     = (k_ff < n_ff);
      status.div_last  = (div_cnt_ff == DIV_W'(1));
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_kind  = rec_kind_ff;
   assign rsp_bin_index    = rec_idx_ff;
   assign rsp_re_q15       = rec_re_ff;
   assign rsp_im_q15       = rec_im_ff;
   assign rsp_kept_count   = rec_cnt_ff;
   assign rsp_sequence_res = rec_seq_ff;
   assign rsp_total_energy = rec_tot_ff;
   assign rsp_checksum     = rec_csum_ff;
   assign rsp_last         = rec_last_ff;

endmodule

>>> src/spectral_energy_bin_packetizer.sv
// A bin load is taken while idle; the last bin of a frame starts the energy, pairwise ranking,
// selection and peak search passes. Header and tail words appear in the cycle after the request;
// a bin word passes the index, load, divide and output states before it appears.
// Throughput: one request per cycle when idle; busy is high during processing and bin reads.
// Reset (synchronous, active high) resets all control state; no packet is pending.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// spectral_energy_bin_packetizer
// Top level: frame loading, energy ranking and packet record read-out.
// ----------------------------------------------------------------------------
module spectral_energy_bin_packetizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic signed [sebp_pkg::BIN_W-1:0]     req_bin_re,
   input  logic signed [sebp_pkg::BIN_W-1:0]     req_bin_im,
   input  logic                                  csr_wr_en,
   input  logic [sebp_pkg::PCT_W-1:0]            csr_wr_data,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_record_kind,
   output logic [sebp_pkg::IDX_W-1:0]            rsp_bin_index,
   output logic signed [sebp_pkg::Q_W-1:0]       rsp_re_q15,
   output logic signed [sebp_pkg::Q_W-1:0]       rsp_im_q15,
   output logic [sebp_pkg::IDX_W-1:0]            rsp_kept_count,
   output logic [sebp_pkg::SEQ_W-1:0]            rsp_sequence_res,
   output logic [sebp_pkg::TOT_W-1:0]            rsp_total_energy,
   output logic [7:0]                            rsp_checksum,
   output logic                                  rsp_last
);
   import sebp_pkg::*;

   op_type     op;
   status_type status;

   // sequencer
   sebp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .op       (op),
      .busy     (busy)
   );

   // datapath
   sebp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_bin_re       (req_bin_re),
      .req_bin_im       (req_bin_im),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_re_q15       (rsp_re_q15),
      .rsp_im_q15       (rsp_im_q15),
      .rsp_kept_count   (rsp_kept_count),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_total_energy (rsp_total_energy),
      .rsp_checksum     (rsp_checksum),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // a loaded word never produces a result word
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_kind |=> !rsp_valid)
      else $error("result word after a bin load");

   // the end marker travels only with the tail word
   a_last_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_record_kind == REC_TAIL)
      else $error("last set on a non-tail word");

   // scaled bins stay within symmetric Q15 range
   a_q15_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_BIN |->
         rsp_re_q15 != 16'sh8000 && rsp_im_q15 != 16'sh8000)
      else $error("Q15 value out of range");
`endif

endmodule
